FILE: rtl/c2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types and constants for the Cartesian to spherical converter: the
// angle mode codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // Width of the CORDIC angle accumulator, in units of pi/2^31.
  localparam int ACC_BITS = 34;

  // Width of every result field.
  localparam int OUT_BITS = 16;

  // Number of entries in the arctangent table.
  localparam int ATAN_ENTRIES = 32;

  // How the polar angle is formed for one request.
  typedef enum logic [2:0] {
    PM_ZERO,
    PM_TOP,
    PM_BOTTOM,
    PM_EQUATOR,
    PM_UPPER,
    PM_LOWER
  } polar_mode_t;

  // How the azimuth is formed for one request.
  typedef enum logic [1:0] {
    AM_ZERO,
    AM_POS,
    AM_NEG,
    AM_CORDIC
  } azim_mode_t;

  // atan(2^-i) in units of pi/2^31.
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

FILE: rtl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One digit step of two restoring square roots running side by side. Each
// cell settles one root bit per lane and hands the partial state on.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell #(
  parameter int ROOT_BITS = 24,
  parameter int PAY_BITS  = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [PAY_BITS-1:0]            in_pay,
  input  logic [1:0][ROOT_BITS+1:0]      in_rem,
  input  logic [1:0][ROOT_BITS-1:0]      in_root,
  input  logic [1:0][2*ROOT_BITS-1:0]    in_rad,
  output logic                           out_valid,
  output logic [PAY_BITS-1:0]            out_pay,
  output logic [1:0][ROOT_BITS+1:0]      out_rem,
  output logic [1:0][ROOT_BITS-1:0]      out_root,
  output logic [1:0][2*ROOT_BITS-1:0]    out_rad
);

  logic [1:0][ROOT_BITS+1:0]   rem_next;
  logic [1:0][ROOT_BITS-1:0]   root_next;
  logic [1:0][2*ROOT_BITS-1:0] rad_next;

  // Bring down the next two radicand bits and try to subtract 4*root+1.
  always_comb begin
    logic [ROOT_BITS+3:0] wide;
    logic [ROOT_BITS+3:0] trial;
    logic [ROOT_BITS+3:0] diff;
    for (int l = 0; l < 2; l++) begin
      wide  = {in_rem[l], in_rad[l][2*ROOT_BITS-1 -: 2]};
      trial = {2'b00, in_root[l], 2'b01};
      diff  = wide - trial;
      if (wide >= trial) begin
        rem_next[l]  = diff[ROOT_BITS+1:0];
        root_next[l] = {in_root[l][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_next[l]  = wide[ROOT_BITS+1:0];
        root_next[l] = {in_root[l][ROOT_BITS-2:0], 1'b0};
      end
      rad_next[l] = in_rad[l] << 2;
    end
  end

  // Valid flag of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Partial state handed to the next cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pay  <= in_pay;
      out_rem  <= rem_next;
      out_root <= root_next;
      out_rad  <= rad_next;
    end
  end

endmodule

FILE: rtl/c2s_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring CORDIC iteration for two lanes (polar and azimuth). The
// cell rotates each vector toward the positive first axis and accumulates
// the angle of its stage.
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
  parameter int STAGE     = 0,
  parameter int VEC_BITS  = 26,
  parameter int SIDE_BITS = 22
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [SIDE_BITS-1:0]                in_side,
  input  logic [1:0][VEC_BITS-1:0]            in_a,
  input  logic [1:0][VEC_BITS-1:0]            in_b,
  input  logic [1:0][c2s_pkg::ACC_BITS-1:0]   in_acc,
  output logic                                out_valid,
  output logic [SIDE_BITS-1:0]                out_side,
  output logic [1:0][VEC_BITS-1:0]            out_a,
  output logic [1:0][VEC_BITS-1:0]            out_b,
  output logic [1:0][c2s_pkg::ACC_BITS-1:0]   out_acc
);
  import c2s_pkg::*;

  localparam logic signed [ACC_BITS-1:0] STEP_ANGLE =
    signed'(ACC_BITS'(ATAN_TAB[STAGE]));

  logic [1:0][VEC_BITS-1:0] a_next;
  logic [1:0][VEC_BITS-1:0] b_next;
  logic [1:0][ACC_BITS-1:0] acc_next;

  // Rotate by +/- atan(2^-STAGE), steering b toward zero.
  always_comb begin
    logic signed [VEC_BITS-1:0] a;
    logic signed [VEC_BITS-1:0] b;
    logic signed [ACC_BITS-1:0] acc;
    for (int l = 0; l < 2; l++) begin
      a   = signed'(in_a[l]);
      b   = signed'(in_b[l]);
      acc = signed'(in_acc[l]);
      if (b > 0) begin
        a_next[l]   = a + (b >>> STAGE);
        b_next[l]   = b - (a >>> STAGE);
        acc_next[l] = acc + STEP_ANGLE;
      end else begin
        a_next[l]   = a - (b >>> STAGE);
        b_next[l]   = b + (a >>> STAGE);
        acc_next[l] = acc - STEP_ANGLE;
      end
    end
  end

  // Valid flag of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Rotated vectors and angles handed to the next cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= in_side;
      out_a    <= a_next;
      out_b    <= b_next;
      out_acc  <= acc_next;
    end
  end

endmodule

FILE: rtl/cartesian_to_spherical_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unit
// Converts a point (x, y, z) to radius, polar angle from +y and azimuth
// atan(z/x), angles in units of pi/32768.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock while the output is not stalled and
// returns one result per request in order. The pipeline is the input,
// magnitude, square and sum registers, one cell per root bit in the square
// root row (COORD_BITS + FRAC bits, FRAC being 8 up to 24-bit coordinates,
// else 0), a setup register, one cell per CORDIC iteration and the output
// register. The whole pipeline holds while a result waits.
module cartesian_to_spherical_unit #(
  parameter int COORD_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 point_valid,
  output logic                                 point_stall,
  input  logic signed [COORD_BITS-1:0]         x_coord,
  input  logic signed [COORD_BITS-1:0]         y_coord,
  input  logic signed [COORD_BITS-1:0]         z_coord,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [c2s_pkg::OUT_BITS-1:0]         radius,
  output logic [c2s_pkg::OUT_BITS-1:0]         polar_angle,
  output logic signed [c2s_pkg::OUT_BITS-1:0]  azimuth
);
  import c2s_pkg::*;

  localparam int N    = COORD_BITS;
  localparam int FRAC = (N <= 24) ? 8 : 0;
  localparam int M    = N + FRAC;
  localparam int W    = N + FRAC + 2;
  localparam int K    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int PW   = 3 * N;
  localparam int SW   = N + 1 + 3 + 2;

  localparam logic signed [ACC_BITS:0] HALF_LSB   = (ACC_BITS + 1)'(32768);
  localparam logic signed [ACC_BITS:0] LOWER_BIAS = (ACC_BITS + 1)'(64'd1 << 30);
  localparam logic signed [ACC_BITS:0] QUARTER    = (ACC_BITS + 1)'(16384);
  localparam logic signed [ACC_BITS:0] HALF_TURN  = (ACC_BITS + 1)'(32768);

  logic adv;

  // Whole pipeline moves when the output register is free or being taken.
  assign adv         = !result_valid || !result_stall;
  assign point_stall = !adv;

  // Input, magnitude, square and sum stages.
  logic                 v0, v1, v2, v3;
  logic signed [N-1:0]  x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic [N-1:0]         ax1, ay1, az1;
  logic [2*N-1:0]       sx2, sy2, sz2, sxz3, sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= point_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0   <= x_coord;
      y0   <= y_coord;
      z0   <= z_coord;
      x1   <= x0;
      y1   <= y0;
      z1   <= z0;
      ax1  <= x0[N-1] ? N'(-x0) : N'(x0);
      ay1  <= y0[N-1] ? N'(-y0) : N'(y0);
      az1  <= z0[N-1] ? N'(-z0) : N'(z0);
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      sx2  <= ax1 * ax1;
      sy2  <= ay1 * ay1;
      sz2  <= az1 * az1;
      x3   <= x2;
      y3   <= y2;
      z3   <= z2;
      sxz3 <= sx2 + sz2;
      sum3 <= sx2 + sz2 + sy2;
    end
  end

  // Square root row: lane 0 takes the full sum, lane 1 takes x^2+z^2 scaled.
  logic                    sq_valid [0:M];
  logic [PW-1:0]           sq_pay   [0:M];
  logic [1:0][M+1:0]       sq_rem   [0:M];
  logic [1:0][M-1:0]       sq_root  [0:M];
  logic [1:0][2*M-1:0]     sq_rad   [0:M];

  assign sq_valid[0]  = v3;
  assign sq_pay[0]    = {x3, y3, z3};
  assign sq_rem[0]    = '0;
  assign sq_root[0]   = '0;
  assign sq_rad[0][0] = (2 * M)'(sum3);
  assign sq_rad[0][1] = (2 * M)'(sxz3) << (2 * FRAC);

  for (genvar i = 0; i < M; i++) begin : g_sqrt
    c2s_sqrt_cell #(
      .ROOT_BITS (M),
      .PAY_BITS  (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (sq_valid[i]),
      .in_pay    (sq_pay[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_rad    (sq_rad[i]),
      .out_valid (sq_valid[i+1]),
      .out_pay   (sq_pay[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_rad   (sq_rad[i+1])
    );
  end

  // CORDIC row signals.
  logic                        cd_valid [0:K];
  logic [SW-1:0]               cd_side  [0:K];
  logic [1:0][W-1:0]           cd_a     [0:K];
  logic [1:0][W-1:0]           cd_b     [0:K];
  logic [1:0][ACC_BITS-1:0]    cd_acc   [0:K];

  // Setup: rounding of the radius, special cases and CORDIC start vectors.
  logic signed [N-1:0] px, py, pz;
  logic [N:0]          rr;
  logic signed [W-1:0] rho_w, yf, xf, zf;
  polar_mode_t         pmode;
  azim_mode_t          amode;
  logic [1:0][W-1:0]   a_init, b_init;

  assign px    = sq_pay[M][3*N-1 -: N];
  assign py    = sq_pay[M][2*N-1 -: N];
  assign pz    = sq_pay[M][N-1:0];
  assign rho_w = signed'(W'(sq_root[M][1]));
  assign yf    = W'(py) <<< FRAC;
  assign xf    = W'(px) <<< FRAC;
  assign zf    = W'(pz) <<< FRAC;

  always_comb begin
    rr = (N + 1)'(sq_root[M][0])
       + (N + 1)'(sq_rem[M][0] > (M + 2)'(sq_root[M][0]));
    a_init = '0;
    b_init = '0;
    priority if (px == '0 && py == '0 && pz == '0) begin
      pmode = PM_ZERO;
    end else if (sq_root[M][1] == '0) begin
      pmode = (py > 0) ? PM_TOP : PM_BOTTOM;
    end else if (py == '0) begin
      pmode = PM_EQUATOR;
    end else if (py > 0) begin
      pmode     = PM_UPPER;
      a_init[0] = yf;
      b_init[0] = rho_w;
    end else begin
      pmode     = PM_LOWER;
      a_init[0] = rho_w;
      b_init[0] = -yf;
    end
    priority if (px == '0) begin
      amode = (pz > 0) ? AM_POS : ((pz < 0) ? AM_NEG : AM_ZERO);
    end else if (pz == '0) begin
      amode = AM_ZERO;
    end else begin
      amode     = AM_CORDIC;
      a_init[1] = (px < 0) ? -xf : xf;
      b_init[1] = (px < 0) ? -zf : zf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_valid[0] <= 1'b0;
    end else if (adv) begin
      cd_valid[0] <= sq_valid[M];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_side[0] <= {rr, pmode, amode};
      cd_a[0]    <= a_init;
      cd_b[0]    <= b_init;
      cd_acc[0]  <= '0;
    end
  end

  for (genvar i = 0; i < K; i++) begin : g_cordic
    c2s_cordic_cell #(
      .STAGE     (i),
      .VEC_BITS  (W),
      .SIDE_BITS (SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (cd_valid[i]),
      .in_side   (cd_side[i]),
      .in_a      (cd_a[i]),
      .in_b      (cd_b[i]),
      .in_acc    (cd_acc[i]),
      .out_valid (cd_valid[i+1]),
      .out_side  (cd_side[i+1]),
      .out_a     (cd_a[i+1]),
      .out_b     (cd_b[i+1]),
      .out_acc   (cd_acc[i+1])
    );
  end

  // Final angles: scale to pi/32768 with rounding, clamp, apply special cases.
  logic [N:0]               rr_k;
  polar_mode_t              pmode_k;
  azim_mode_t               amode_k;
  logic signed [ACC_BITS:0] pol_sum, pol_scaled, az_scaled;
  logic [OUT_BITS-1:0]      polar_next;
  logic [OUT_BITS-1:0]      azim_next;

  assign rr_k    = cd_side[K][SW-1 -: N+1];
  assign pmode_k = polar_mode_t'(cd_side[K][4:2]);
  assign amode_k = azim_mode_t'(cd_side[K][1:0]);

  always_comb begin
    pol_sum = (ACC_BITS + 1)'(signed'(cd_acc[K][0]))
            + ((pmode_k == PM_LOWER) ? LOWER_BIAS : '0);
    pol_scaled = (pol_sum + HALF_LSB) >>> 16;
    az_scaled  = ((ACC_BITS + 1)'(signed'(cd_acc[K][1])) + HALF_LSB) >>> 16;
    unique case (pmode_k)
      PM_BOTTOM:  polar_next = OUT_BITS'(HALF_TURN);
      PM_EQUATOR: polar_next = OUT_BITS'(QUARTER);
      PM_UPPER, PM_LOWER: begin
        priority if (pol_scaled < 0) begin
          polar_next = '0;
        end else if (pol_scaled > HALF_TURN) begin
          polar_next = OUT_BITS'(HALF_TURN);
        end else begin
          polar_next = OUT_BITS'(pol_scaled);
        end
      end
      default:    polar_next = '0;
    endcase
    unique case (amode_k)
      AM_POS: azim_next = OUT_BITS'(QUARTER);
      AM_NEG: azim_next = OUT_BITS'(-QUARTER);
      AM_CORDIC: begin
        priority if (az_scaled < -QUARTER) begin
          azim_next = OUT_BITS'(-QUARTER);
        end else if (az_scaled > QUARTER) begin
          azim_next = OUT_BITS'(QUARTER);
        end else begin
          azim_next = OUT_BITS'(az_scaled);
        end
      end
      default: azim_next = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= cd_valid[K];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      radius      <= OUT_BITS'(rr_k);
      polar_angle <= polar_next;
      azimuth     <= signed'(azim_next);
    end
  end

endmodule
